FILE: hw/rtl/va2f4_pkg.sv
// ----------------------------------------------------------------------------
// Vertex attribute converter package
// Shared types, format codes and register indexes.
// ----------------------------------------------------------------------------
package va2f4_pkg;

  typedef enum logic [1:0] {
    FMT_SBYTE  = 2'd0,
    FMT_UBYTE  = 2'd1,
    FMT_SSHORT = 2'd2,
    FMT_FLOAT  = 2'd3
  } scalar_fmt_e;

  typedef enum logic [1:0] {
    REG_SCALAR_FORMAT   = 2'd0,
    REG_COMPONENT_COUNT = 2'd1,
    REG_SOURCE_OFFSET   = 2'd2,
    REG_ELEMENT_STRIDE  = 2'd3
  } reg_idx_e;

  localparam logic [31:0] BitsOne  = 32'h3F80_0000;
  localparam logic [31:0] BitsZero = 32'h0000_0000;
  localparam int unsigned Lanes    = 4;

  typedef struct packed {
    logic [63:0] source_low;
    logic [63:0] source_high;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [31:0] out_w;
    logic        bounds_error;
  } out_beat_t;

endpackage

FILE: hw/rtl/va2f4_int_to_float.sv
// ----------------------------------------------------------------------------
// Integer to single-precision converter
// Exact conversion of a 17-bit signed integer to IEEE single bits.
// ----------------------------------------------------------------------------
module va2f4_int_to_float
  import va2f4_pkg::*;
(
  input  logic signed [16:0] value_i,
  output logic        [31:0] bits_o
);

  logic        sign;
  logic [16:0] mag;
  logic [4:0]  msb;
  logic [16:0] norm;

  // Magnitude and leading-one position; every value fits the mantissa.
  always_comb begin
    sign = value_i[16];
    mag  = sign ? 17'(-value_i) : 17'(value_i);
    msb  = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (mag[i]) msb = 5'(i);
    end
    norm = mag << (5'd16 - msb);
    if (mag == 17'd0) begin
      bits_o = BitsZero;
    end else begin
      bits_o = {sign, 8'(8'd127 + {3'd0, msb}), norm[15:0], 7'd0};
    end
  end

endmodule

FILE: hw/rtl/vertex_attribute_to_float4.sv
// ----------------------------------------------------------------------------
// Vertex attribute to float4
// Decodes one raw vertex attribute into four single-precision components.
// ----------------------------------------------------------------------------
// Usage: an input beat carries 16 little-endian attribute bytes on in_valid /
// in_ready. The four configuration registers are written through cfg_valid /
// cfg_ready (index, data) while the block is idle; cfg_ready is always high.
// Each beat is decoded combinationally between the input register and the
// output register and is presented from the output register. Throughput is
// one beat per cycle while the output is not stalled, set by the single
// decode stage. When the receiver stalls, the output register holds and the
// input register keeps its beat; ready drops only when both are full, so no
// beat is lost. Reset empties both stages and loads the register defaults:
// float format, four components, offset 0, stride 16. Attributes that run
// past the stride give zeros with bounds_error set.
// ----------------------------------------------------------------------------
module vertex_attribute_to_float4
  import va2f4_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data_i,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data_o,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  scalar_fmt_e fmt_q;
  logic [2:0]  count_q;
  logic [7:0]  offset_q;
  logic [7:0]  stride_q;

  in_beat_t  in_q;
  logic      in_vld_q;
  out_beat_t out_q;
  logic      out_vld_q;
  out_beat_t res_d;
  logic      adv;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_FLOAT;
      count_q  <= 3'd4;
      offset_q <= 8'd0;
      stride_q <= 8'd16;
    end else if (cfg_valid) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_SCALAR_FORMAT:   fmt_q    <= scalar_fmt_e'(cfg_data_i[1:0]);
        REG_COMPONENT_COUNT: count_q  <= cfg_data_i[2:0];
        REG_SOURCE_OFFSET:   offset_q <= cfg_data_i;
        REG_ELEMENT_STRIDE:  stride_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Two-stage handshake: the decode stage moves whenever the output is free.
  assign adv       = in_vld_q && (!out_vld_q || out_ready);
  assign in_ready  = !in_vld_q || adv;
  assign out_valid = out_vld_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready) in_vld_q <= in_valid;
      if (adv) out_vld_q <= 1'b1;
      else if (out_ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid) in_q <= in_data_i;
    if (adv) out_q <= res_d;
  end

  // Decode: component c starts at byte c times the scalar size.
  logic [127:0]       bytes;
  logic [10:0]        need;
  logic [2:0]         size;
  logic               err;
  logic signed [16:0] ival [Lanes];
  logic [31:0]        fbits [Lanes];
  logic [31:0]        raw [Lanes];
  logic [31:0]        comp [Lanes];

  assign bytes = {in_q.source_high, in_q.source_low};

  always_comb begin
    unique case (fmt_q)
      FMT_SSHORT: size = 3'd2;
      FMT_FLOAT:  size = 3'd4;
      default:    size = 3'd1;
    endcase
    need = {3'd0, offset_q} + ({8'd0, size} * {8'd0, count_q});
    err  = (count_q > 3'd4) || (stride_q == 8'd0) || (need > {3'd0, stride_q});
  end

  for (genvar c = 0; c < Lanes; c++) begin : g_lane
    always_comb begin
      unique case (fmt_q)
        FMT_SBYTE:  ival[c] = 17'(signed'(bytes[8*c +: 8]));
        FMT_UBYTE:  ival[c] = {9'd0, bytes[8*c +: 8]};
        FMT_SSHORT: ival[c] = 17'(signed'(bytes[16*c +: 16]));
        default:    ival[c] = 17'sd0;
      endcase
      raw[c] = bytes[32*c +: 32];
    end

    va2f4_int_to_float u_cvt (
      .value_i(ival[c]),
      .bits_o (fbits[c])
    );

    always_comb begin
      if (err) begin
        comp[c] = BitsZero;
      end else if (3'(c) < count_q) begin
        comp[c] = (fmt_q == FMT_FLOAT) ? raw[c] : fbits[c];
      end else begin
        comp[c] = (c == Lanes - 1) ? BitsOne : BitsZero;
      end
    end
  end

  assign res_d = '{out_x: comp[0], out_y: comp[1], out_z: comp[2],
                   out_w: comp[3], bounds_error: err};

endmodule
